// ===== rtl/core/sweep_calibration_min_max_sequencer_top_assert.svh =====
// Assertion macros for the calibration sweep sequencer.
// Every macro expects signals named clk and rst_n where it is used.
`ifndef SWEEP_CALIBRATION_MIN_MAX_SEQUENCER_TOP_ASSERT_SVH
`define SWEEP_CALIBRATION_MIN_MAX_SEQUENCER_TOP_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SWCAL_ASSERT_SAME(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("swcal same cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define SWCAL_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("swcal next cycle check failed");

`endif

// ===== rtl/core/swcal_pkg.sv =====
// Shared types and constants of the calibration sweep sequencer.
// No dependencies; the interfaces and the top level import this package.
package swcal_pkg;

    localparam int SAMPLE_W = 16;
    localparam int TIME_W   = 32;
    localparam int RPD_W    = 8;
    localparam int CYC_W    = 7;
    localparam int COUNT_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    localparam logic [CFG_IDX_W-1:0] CFG_READS_PER_DIR = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CYCLE_COUNT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_SETTLE_DELAY  = 2'd2;

    localparam logic [RPD_W-1:0]    RESET_READS_PER_DIR = 8'd4;
    localparam logic [CYC_W-1:0]    RESET_CYCLE_COUNT   = 7'd2;
    localparam logic [SAMPLE_W-1:0] RESET_SETTLE_DELAY  = 16'd100;
    localparam logic [SAMPLE_W-1:0] SAMPLE_ALL_ONES     = 16'hFFFF;

    typedef enum logic [2:0] {
        PH_IDLE    = 3'd0,
        PH_REQUEST = 3'd1,
        PH_WAIT    = 3'd2,
        PH_PROCESS = 3'd3,
        PH_DONE    = 3'd4
    } phase_t;

    typedef struct packed {
        logic                cmd;
        logic                motor_accepted;
        logic [TIME_W-1:0]   now_ms;
        logic [SAMPLE_W-1:0] sample_ch1;
        logic [SAMPLE_W-1:0] sample_ch2;
    } item_t;

    typedef struct packed {
        logic                busy_res;
        logic                start_rejected;
        logic                step_request;
        logic                step_direction;
        logic                done_res;
        logic [SAMPLE_W-1:0] max_ch1;
        logic [SAMPLE_W-1:0] min_ch1;
        logic [SAMPLE_W-1:0] max_ch2;
        logic [SAMPLE_W-1:0] min_ch2;
    } result_t;

endpackage

// ===== rtl/core/swcal_in_if.sv =====
// Request channel carrying one command or poll of the sequencer.
// Depends on swcal_pkg for the field widths.
interface swcal_in_if
    import swcal_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                cmd;
    logic                motor_accepted;
    logic [TIME_W-1:0]   now_ms;
    logic [SAMPLE_W-1:0] sample_ch1;
    logic [SAMPLE_W-1:0] sample_ch2;

    modport source (output valid, cmd, motor_accepted, now_ms, sample_ch1, sample_ch2,
                    input ready);
    modport sink   (input valid, cmd, motor_accepted, now_ms, sample_ch1, sample_ch2,
                    output ready);
endinterface

// ===== rtl/core/swcal_out_if.sv =====
// Result channel carrying one status and extremes result per request.
// Depends on swcal_pkg for the field widths.
interface swcal_out_if
    import swcal_pkg::*;
;
    logic                valid;
    logic                ready;
    logic                busy_res;
    logic                start_rejected;
    logic                step_request;
    logic                step_direction;
    logic                done_res;
    logic [SAMPLE_W-1:0] max_ch1;
    logic [SAMPLE_W-1:0] min_ch1;
    logic [SAMPLE_W-1:0] max_ch2;
    logic [SAMPLE_W-1:0] min_ch2;

    modport source (output valid, busy_res, start_rejected, step_request, step_direction,
                    done_res, max_ch1, min_ch1, max_ch2, min_ch2,
                    input ready);
    modport sink   (input valid, busy_res, start_rejected, step_request, step_direction,
                    done_res, max_ch1, min_ch1, max_ch2, min_ch2,
                    output ready);
endinterface

// ===== rtl/core/swcal_cfg_if.sv =====
// Configuration write channel: register index and write data.
// Depends on swcal_pkg for the field widths.
interface swcal_cfg_if
    import swcal_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

// ===== rtl/core/sweep_calibration_min_max_sequencer_top.sv =====
// Pipeline: an accepted request enters the input register; its result is registered in the output register.
// Throughput: one request per cycle; while a result waits, one more request fills the input
// register and then the input stalls until the waiting result is taken.
// Reset (rst_n low, asynchronous): sequencer idle, configuration at its defaults,
// both pipeline registers empty.
// Depends on swcal_pkg, the three channel interfaces and the assertion header.
`include "sweep_calibration_min_max_sequencer_top_assert.svh"

module sweep_calibration_min_max_sequencer_top
    import swcal_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    swcal_in_if.sink    sample,
    swcal_out_if.source result,
    swcal_cfg_if.sink   cfg
);

    logic [RPD_W-1:0]    reads_per_dir_reg;
    logic [CYC_W-1:0]    cycle_count_reg;
    logic [SAMPLE_W-1:0] settle_delay_reg;

    logic    s1_valid_reg;
    item_t   s1_item_reg;
    logic    out_valid_reg;
    result_t out_item_reg;
    logic    s1_advance;
    logic    process_fire;

    phase_t              phase_reg, phase_next;
    logic                direction_reg, direction_next;
    logic [COUNT_W-1:0]  halves_reg, halves_next;
    logic [COUNT_W-1:0]  reads_reg, reads_next;
    logic [SAMPLE_W-1:0] high_ch1_reg, high_ch1_next;
    logic [SAMPLE_W-1:0] low_ch1_reg, low_ch1_next;
    logic [SAMPLE_W-1:0] high_ch2_reg, high_ch2_next;
    logic [SAMPLE_W-1:0] low_ch2_reg, low_ch2_next;
    logic [TIME_W-1:0]   deadline_reg, deadline_next;
    logic [SAMPLE_W-1:0] held_ch1_reg, held_ch1_next;
    logic [SAMPLE_W-1:0] held_ch2_reg, held_ch2_next;
    logic [COUNT_W-1:0]  reads_inc;
    result_t             res_next;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reads_per_dir_reg <= RESET_READS_PER_DIR;
            cycle_count_reg   <= RESET_CYCLE_COUNT;
            settle_delay_reg  <= RESET_SETTLE_DELAY;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_READS_PER_DIR: reads_per_dir_reg <= cfg.data[RPD_W-1:0];
                CFG_CYCLE_COUNT:   cycle_count_reg   <= cfg.data[CYC_W-1:0];
                CFG_SETTLE_DELAY:  settle_delay_reg  <= cfg.data[SAMPLE_W-1:0];
                default:           ;
            endcase
        end
    end

    assign s1_advance   = !out_valid_reg || result.ready;
    assign process_fire = s1_valid_reg && s1_advance;
    assign sample.ready = !s1_valid_reg || s1_advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (sample.valid && sample.ready)
        begin
            s1_valid_reg <= 1'b1;
        end
        else if (s1_advance)
        begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sample.valid && sample.ready)
        begin
            s1_item_reg.cmd            <= sample.cmd;
            s1_item_reg.motor_accepted <= sample.motor_accepted;
            s1_item_reg.now_ms         <= sample.now_ms;
            s1_item_reg.sample_ch1     <= sample.sample_ch1;
            s1_item_reg.sample_ch2     <= sample.sample_ch2;
        end
    end

    always_comb
    begin
        phase_next     = phase_reg;
        direction_next = direction_reg;
        halves_next    = halves_reg;
        reads_next     = reads_reg;
        high_ch1_next  = high_ch1_reg;
        low_ch1_next   = low_ch1_reg;
        high_ch2_next  = high_ch2_reg;
        low_ch2_next   = low_ch2_reg;
        deadline_next  = deadline_reg;
        held_ch1_next  = held_ch1_reg;
        held_ch2_next  = held_ch2_reg;
        reads_inc      = reads_reg + 8'd1;
        res_next       = '0;

        if (s1_item_reg.cmd)
        begin
            if (phase_reg != PH_IDLE)
            begin
                res_next.start_rejected = 1'b1;
            end
            else
            begin
                phase_next     = PH_REQUEST;
                direction_next = 1'b0;
                halves_next    = '0;
                reads_next     = '0;
                high_ch1_next  = '0;
                low_ch1_next   = SAMPLE_ALL_ONES;
                high_ch2_next  = '0;
                low_ch2_next   = SAMPLE_ALL_ONES;
            end
        end
        else
        begin
            case (phase_reg)
                PH_REQUEST:
                begin
                    res_next.step_request   = 1'b1;
                    res_next.step_direction = direction_reg;
                    if (s1_item_reg.motor_accepted)
                    begin
                        deadline_next = s1_item_reg.now_ms
                                      + {{(TIME_W-SAMPLE_W){1'b0}}, settle_delay_reg};
                        phase_next    = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (!(s1_item_reg.now_ms < deadline_reg))
                    begin
                        held_ch1_next = s1_item_reg.sample_ch1;
                        held_ch2_next = s1_item_reg.sample_ch2;
                        phase_next    = PH_PROCESS;
                    end
                end
                PH_PROCESS:
                begin
                    if (held_ch1_reg > high_ch1_reg) high_ch1_next = held_ch1_reg;
                    if (held_ch1_reg < low_ch1_reg)  low_ch1_next  = held_ch1_reg;
                    if (held_ch2_reg > high_ch2_reg) high_ch2_next = held_ch2_reg;
                    if (held_ch2_reg < low_ch2_reg)  low_ch2_next  = held_ch2_reg;
                    reads_next = reads_inc;
                    if (reads_inc >= reads_per_dir_reg)
                    begin
                        reads_next     = '0;
                        direction_next = !direction_reg;
                        halves_next    = halves_reg + 8'd1;
                    end
                    if (halves_next >= {cycle_count_reg, 1'b0})
                    begin
                        phase_next = PH_DONE;
                    end
                    else
                    begin
                        phase_next = PH_REQUEST;
                    end
                end
                PH_DONE:
                begin
                    res_next.done_res = 1'b1;
                    res_next.max_ch1  = high_ch1_reg;
                    res_next.min_ch1  = low_ch1_reg;
                    res_next.max_ch2  = high_ch2_reg;
                    res_next.min_ch2  = low_ch2_reg;
                    phase_next        = PH_IDLE;
                end
                default:
                begin
                    phase_next = phase_reg;
                end
            endcase
        end

        res_next.busy_res = (phase_next != PH_IDLE);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            direction_reg <= 1'b0;
            halves_reg    <= '0;
            reads_reg     <= '0;
            high_ch1_reg  <= '0;
            low_ch1_reg   <= SAMPLE_ALL_ONES;
            high_ch2_reg  <= '0;
            low_ch2_reg   <= SAMPLE_ALL_ONES;
            deadline_reg  <= '0;
            held_ch1_reg  <= '0;
            held_ch2_reg  <= '0;
        end
        else if (process_fire)
        begin
            phase_reg     <= phase_next;
            direction_reg <= direction_next;
            halves_reg    <= halves_next;
            reads_reg     <= reads_next;
            high_ch1_reg  <= high_ch1_next;
            low_ch1_reg   <= low_ch1_next;
            high_ch2_reg  <= high_ch2_next;
            low_ch2_reg   <= low_ch2_next;
            deadline_reg  <= deadline_next;
            held_ch1_reg  <= held_ch1_next;
            held_ch2_reg  <= held_ch2_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (process_fire)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (process_fire)
        begin
            out_item_reg <= res_next;
        end
    end

    assign result.valid          = out_valid_reg;
    assign result.busy_res       = out_item_reg.busy_res;
    assign result.start_rejected = out_item_reg.start_rejected;
    assign result.step_request   = out_item_reg.step_request;
    assign result.step_direction = out_item_reg.step_direction;
    assign result.done_res       = out_item_reg.done_res;
    assign result.max_ch1        = out_item_reg.max_ch1;
    assign result.min_ch1        = out_item_reg.min_ch1;
    assign result.max_ch2        = out_item_reg.max_ch2;
    assign result.min_ch2        = out_item_reg.min_ch2;

    `SWCAL_ASSERT_SAME(a_done_ends_run, result.valid && result.done_res, !result.busy_res)
    `SWCAL_ASSERT_SAME(a_dir_only_with_step, result.valid && !result.step_request,
                       !result.step_direction)
    `SWCAL_ASSERT_NEXT(a_done_phase_to_idle,
                       process_fire && !s1_item_reg.cmd && phase_reg == PH_DONE,
                       phase_reg == PH_IDLE && out_valid_reg)
    `SWCAL_ASSERT_SAME(a_stall_only_when_full, !sample.ready, s1_valid_reg && out_valid_reg)

endmodule

// ===== bench/sweep_calibration_min_max_sequencer_top_test.sv =====
`timescale 1ns / 1ps
// Self-checking bench for the calibration sweep sequencer: a directed table, then random runs.
// Needs swcal_pkg, the three channel interfaces and sweep_calibration_min_max_sequencer_top.
module sweep_calibration_min_max_sequencer_top_test;
    import swcal_pkg::*;

    localparam logic CMD_POLL  = 1'b0;
    localparam logic CMD_START = 1'b1;
    localparam int   WATCHDOG_LIMIT  = 1000;
    localparam int   RUN_PHASES      = 12;
    localparam int   ITEMS_PER_PHASE = 120;
    localparam int   REPORT_LIMIT    = 10;

    typedef struct {
        bit                    is_write;
        logic [CFG_IDX_W-1:0]  reg_index;
        logic [CFG_DATA_W-1:0] reg_value;
        item_t                 req;
        bit                    typed;
        result_t               want;
    } plan_row_t;

    logic clk = 1'b0;
    logic rst_n;

    swcal_in_if  req_bus ();
    swcal_out_if res_bus ();
    swcal_cfg_if cfg_bus ();

    sweep_calibration_min_max_sequencer_top dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .sample (req_bus),
        .result (res_bus),
        .cfg    (cfg_bus)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Shadow copy of the sequencer state and its registers.
    logic [RPD_W-1:0]    reads_per_dir_cfg;
    logic [CYC_W-1:0]    cycles_cfg;
    logic [SAMPLE_W-1:0] settle_cfg;
    phase_t              sweep_phase;
    logic                sweep_dir;
    logic [COUNT_W-1:0]  halves_done;
    logic [COUNT_W-1:0]  reads_done;
    logic [SAMPLE_W-1:0] top_ch1, bottom_ch1, top_ch2, bottom_ch2;
    logic [SAMPLE_W-1:0] held_ch1, held_ch2;
    logic [TIME_W-1:0]   settle_deadline;

    result_t     pending_status_q[$];
    plan_row_t   plan[$];
    int          mismatches = 0;
    int          idle_cycles = 0;
    bit          sender_gaps = 1'b1;
    bit          sink_stalls = 1'b1;
    logic [31:0] clock_ms = 32'd0;
    int          wait_polls = 0;

    function automatic result_t advance_sweep(input item_t it);
        result_t r;
        r = '0;
        if (it.cmd == CMD_START) begin
            if (sweep_phase != PH_IDLE) begin
                r.start_rejected = 1'b1;
            end else begin
                sweep_phase = PH_REQUEST;
                sweep_dir   = 1'b0;
                halves_done = '0;
                reads_done  = '0;
                top_ch1     = '0;
                bottom_ch1  = SAMPLE_ALL_ONES;
                top_ch2     = '0;
                bottom_ch2  = SAMPLE_ALL_ONES;
            end
        end else begin
            case (sweep_phase)
                PH_REQUEST:
                begin
                    r.step_request   = 1'b1;
                    r.step_direction = sweep_dir;
                    if (it.motor_accepted) begin
                        settle_deadline = it.now_ms + {16'd0, settle_cfg};
                        sweep_phase     = PH_WAIT;
                    end
                end
                PH_WAIT:
                begin
                    if (it.now_ms >= settle_deadline) begin
                        held_ch1    = it.sample_ch1;
                        held_ch2    = it.sample_ch2;
                        sweep_phase = PH_PROCESS;
                    end
                end
                PH_PROCESS:
                begin
                    if (held_ch1 > top_ch1) top_ch1 = held_ch1;
                    if (held_ch1 < bottom_ch1) bottom_ch1 = held_ch1;
                    if (held_ch2 > top_ch2) top_ch2 = held_ch2;
                    if (held_ch2 < bottom_ch2) bottom_ch2 = held_ch2;
                    reads_done = reads_done + 1'b1;
                    if (reads_done >= reads_per_dir_cfg) begin
                        reads_done  = '0;
                        sweep_dir   = ~sweep_dir;
                        halves_done = halves_done + 1'b1;
                    end
                    sweep_phase = (halves_done >= {cycles_cfg, 1'b0}) ? PH_DONE : PH_REQUEST;
                end
                PH_DONE:
                begin
                    r.done_res  = 1'b1;
                    r.max_ch1   = top_ch1;
                    r.min_ch1   = bottom_ch1;
                    r.max_ch2   = top_ch2;
                    r.min_ch2   = bottom_ch2;
                    sweep_phase = PH_IDLE;
                end
                default:
                begin
                end
            endcase
        end
        r.busy_res = (sweep_phase != PH_IDLE);
        return r;
    endfunction

    function automatic result_t status_word(logic busy, logic rejected, logic step, logic dir);
        result_t r;
        r = '0;
        r.busy_res       = busy;
        r.start_rejected = rejected;
        r.step_request   = step;
        r.step_direction = dir;
        return r;
    endfunction

    function automatic plan_row_t request_row(logic cmd, logic accepted, logic [TIME_W-1:0] now,
                                              logic [SAMPLE_W-1:0] ch1, logic [SAMPLE_W-1:0] ch2,
                                              bit typed, result_t want);
        plan_row_t row;
        row.is_write  = 1'b0;
        row.reg_index = '0;
        row.reg_value = '0;
        row.req.cmd            = cmd;
        row.req.motor_accepted = accepted;
        row.req.now_ms         = now;
        row.req.sample_ch1     = ch1;
        row.req.sample_ch2     = ch2;
        row.typed = typed;
        row.want  = want;
        return row;
    endfunction

    function automatic plan_row_t write_row(logic [CFG_IDX_W-1:0] idx,
                                            logic [CFG_DATA_W-1:0] value);
        plan_row_t row;
        row.is_write  = 1'b1;
        row.reg_index = idx;
        row.reg_value = value;
        row.req       = '0;
        row.typed     = 1'b0;
        row.want      = '0;
        return row;
    endfunction

    function automatic logic [SAMPLE_W-1:0] pick_sample();
        int pick;
        pick = $urandom_range(0, 7);
        if (pick == 0) return '0;
        if (pick == 1) return SAMPLE_ALL_ONES;
        return SAMPLE_W'($urandom);
    endfunction

    // Mostly well-formed polls that follow the sweep, with some noise mixed in.
    function automatic item_t next_random_request();
        item_t it;
        int    pick;
        it.cmd            = CMD_POLL;
        it.motor_accepted = 1'($urandom_range(0, 1));
        it.now_ms         = $urandom;
        it.sample_ch1     = pick_sample();
        it.sample_ch2     = pick_sample();
        pick = $urandom_range(0, 99);
        if (sweep_phase != PH_WAIT) wait_polls = 0;
        if (pick < 4) begin
            it.cmd = 1'($urandom_range(0, 1));
            return it;
        end
        if (sweep_phase == PH_IDLE) begin
            it.cmd = (pick < 75) ? CMD_START : CMD_POLL;
            return it;
        end
        if (pick < 10) begin
            it.cmd = CMD_START;
            return it;
        end
        case (sweep_phase)
            PH_REQUEST:
            begin
                it.motor_accepted = ($urandom_range(0, 3) != 0);
                clock_ms = clock_ms + $urandom_range(0, 50);
            end
            PH_WAIT:
            begin
                wait_polls++;
                pick = $urandom_range(0, 9);
                if (pick == 0 && settle_deadline != 0)
                    clock_ms = settle_deadline - 1;
                else if (pick == 1)
                    clock_ms = settle_deadline;
                else if (pick == 2 || wait_polls > 4)
                    clock_ms = $urandom_range(32'hFFFF_FFFF, settle_deadline);
                else
                    clock_ms = clock_ms + $urandom_range(0, settle_cfg);
            end
            default:
            begin
                clock_ms = clock_ms + $urandom_range(0, 3);
            end
        endcase
        it.now_ms = clock_ms;
        return it;
    endfunction

    task automatic send_request(input item_t it, input bit typed, input result_t want);
        int gap;
        result_t predicted;
        if (sender_gaps && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 19);
            req_bus.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        req_bus.valid          <= 1'b1;
        req_bus.cmd            <= it.cmd;
        req_bus.motor_accepted <= it.motor_accepted;
        req_bus.now_ms         <= it.now_ms;
        req_bus.sample_ch1     <= it.sample_ch1;
        req_bus.sample_ch2     <= it.sample_ch2;
        do @(posedge clk); while (!req_bus.ready);
        predicted = advance_sweep(it);
        pending_status_q.push_back(typed ? want : predicted);
    endtask

    // Holds off new requests until every result is back and the pipeline has emptied.
    task automatic settle_pipeline();
        req_bus.valid <= 1'b0;
        while (pending_status_q.size() != 0) @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] value);
        settle_pipeline();
        cfg_bus.valid <= 1'b1;
        cfg_bus.index <= idx;
        cfg_bus.data  <= value;
        do @(posedge clk); while (!cfg_bus.ready);
        cfg_bus.valid <= 1'b0;
        case (idx)
            CFG_READS_PER_DIR: reads_per_dir_cfg = value[RPD_W-1:0];
            CFG_CYCLE_COUNT:   cycles_cfg        = value[CYC_W-1:0];
            CFG_SETTLE_DELAY:  settle_cfg        = value[SAMPLE_W-1:0];
            default:
            begin
            end
        endcase
    endtask

    initial
    begin : result_sink
        int stall;
        stall = 0;
        res_bus.ready = 1'b0;
        forever begin
            @(posedge clk);
            if (stall > 0) begin
                res_bus.ready <= 1'b0;
                stall--;
            end else if (sink_stalls && $urandom_range(0, 7) == 0) begin
                res_bus.ready <= 1'b0;
                stall = $urandom_range(1, 19) - 1;
            end else begin
                res_bus.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin : status_check
        result_t got;
        result_t want;
        string   bad;
        if (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) begin
            got = {res_bus.busy_res, res_bus.start_rejected, res_bus.step_request,
                   res_bus.step_direction, res_bus.done_res, res_bus.max_ch1,
                   res_bus.min_ch1, res_bus.max_ch2, res_bus.min_ch2};
            if (pending_status_q.size() == 0) begin
                mismatches++;
                if (mismatches <= REPORT_LIMIT)
                    $display("unexpected result %h with no request waiting", got);
            end else begin
                want = pending_status_q.pop_front();
                bad = "";
                if (got.busy_res !== want.busy_res) bad = {bad, " busy_res"};
                if (got.start_rejected !== want.start_rejected) bad = {bad, " start_rejected"};
                if (got.step_request !== want.step_request) bad = {bad, " step_request"};
                if (got.step_direction !== want.step_direction) bad = {bad, " step_direction"};
                if (got.done_res !== want.done_res) bad = {bad, " done_res"};
                if (got.max_ch1 !== want.max_ch1) bad = {bad, " max_ch1"};
                if (got.min_ch1 !== want.min_ch1) bad = {bad, " min_ch1"};
                if (got.max_ch2 !== want.max_ch2) bad = {bad, " max_ch2"};
                if (got.min_ch2 !== want.min_ch2) bad = {bad, " min_ch2"};
                if (bad != "") begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT) begin
                        $display("mismatch at %0t on%s", $realtime, bad);
                        $display("  expected busy=%0b rej=%0b step=%0b dir=%0b done=%0b %h %h %h %h",
                                 want.busy_res, want.start_rejected, want.step_request,
                                 want.step_direction, want.done_res, want.max_ch1,
                                 want.min_ch1, want.max_ch2, want.min_ch2);
                        $display("  actual   busy=%0b rej=%0b step=%0b dir=%0b done=%0b %h %h %h %h",
                                 got.busy_res, got.start_rejected, got.step_request,
                                 got.step_direction, got.done_res, got.max_ch1,
                                 got.min_ch1, got.max_ch2, got.min_ch2);
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin : watchdog
        if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
            (res_bus.valid === 1'b1 && res_bus.ready === 1'b1) ||
            (cfg_bus.valid === 1'b1 && cfg_bus.ready === 1'b1)) begin
            idle_cycles <= 0;
        end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    initial
    begin : stimulus
        result_t             done_a;
        result_t             done_b;
        logic [RPD_W-1:0]    rpd;
        logic [CYC_W-1:0]    cyc;
        logic [SAMPLE_W-1:0] delay;
        rst_n                  = 1'b0;
        req_bus.valid          = 1'b0;
        req_bus.cmd            = CMD_POLL;
        req_bus.motor_accepted = 1'b0;
        req_bus.now_ms         = '0;
        req_bus.sample_ch1     = '0;
        req_bus.sample_ch2     = '0;
        cfg_bus.valid          = 1'b0;
        cfg_bus.index          = CFG_READS_PER_DIR;
        cfg_bus.data           = '0;

        reads_per_dir_cfg = RESET_READS_PER_DIR;
        cycles_cfg        = RESET_CYCLE_COUNT;
        settle_cfg        = RESET_SETTLE_DELAY;
        sweep_phase       = PH_IDLE;
        sweep_dir         = 1'b0;
        halves_done       = '0;
        reads_done        = '0;
        top_ch1           = '0;
        bottom_ch1        = SAMPLE_ALL_ONES;
        top_ch2           = '0;
        bottom_ch2        = SAMPLE_ALL_ONES;
        settle_deadline   = '0;
        held_ch1          = '0;
        held_ch2          = '0;

        done_a = '{busy_res: 1'b0, start_rejected: 1'b0, step_request: 1'b0,
                   step_direction: 1'b0, done_res: 1'b1, max_ch1: 16'hFFFF,
                   min_ch1: 16'h0000, max_ch2: 16'hFFFF, min_ch2: 16'h0000};
        done_b = '{busy_res: 1'b0, start_rejected: 1'b0, step_request: 1'b0,
                   step_direction: 1'b0, done_res: 1'b1, max_ch1: 16'h1234,
                   min_ch1: 16'h00FF, max_ch2: 16'h8000, min_ch2: 16'h7FFF};

        // Reset defaults: idle poll, start, start while busy, pending step, wrapped deadline.
        plan.push_back(request_row(CMD_POLL, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1, '0));
        plan.push_back(request_row(CMD_START, 1'b0, 32'h0, 16'h0, 16'h0, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(request_row(CMD_START, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                   status_word(1'b1, 1'b1, 1'b0, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'h0, 16'h0, 16'h0, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b1, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b1, 32'hFFFF_FFF0, 16'h0, 16'h0, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b1, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'h0, 16'h0, 16'h0, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b1, 32'h53, 16'h0, 16'h0, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'h54, 16'hFFFF, 16'h0000, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b1, 32'h0, 16'h5A5A, 16'hA5A5, 1'b0, '0));
        // A zero cycle count ends the run after the next reading.
        plan.push_back(write_row(CFG_CYCLE_COUNT, 16'd0));
        plan.push_back(request_row(CMD_POLL, 1'b1, 32'd1000, 16'h0, 16'h0, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b1, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'd2000, 16'h0000, 16'hFFFF, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'd2000, 16'h1111, 16'h2222, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'h0, 16'h0, 16'h0, 1'b1, done_a));
        // Zero reads per direction flips after every reading; zero settle delay.
        plan.push_back(write_row(CFG_READS_PER_DIR, 16'd0));
        plan.push_back(write_row(CFG_CYCLE_COUNT, 16'd1));
        plan.push_back(write_row(CFG_SETTLE_DELAY, 16'd0));
        plan.push_back(request_row(CMD_START, 1'b0, 32'h0, 16'h0, 16'h0, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b0, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b1, 32'd5, 16'h0, 16'h0, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b1, 1'b0)));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'd5, 16'h1234, 16'h8000, 1'b0, '0));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'd5, 16'h0, 16'h0, 1'b0, '0));
        plan.push_back(request_row(CMD_POLL, 1'b1, 32'd6, 16'h0, 16'h0, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b1, 1'b1)));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'd6, 16'h00FF, 16'h7FFF, 1'b0, '0));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'd6, 16'h0, 16'h0, 1'b0, '0));
        plan.push_back(request_row(CMD_POLL, 1'b0, 32'd6, 16'h0, 16'h0, 1'b1, done_b));
        plan.push_back(request_row(CMD_START, 1'b1, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF, 1'b1,
                                   status_word(1'b1, 1'b0, 1'b0, 1'b0)));

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (plan[i]) begin
            if (plan[i].is_write)
                write_reg(plan[i].reg_index, plan[i].reg_value);
            else
                send_request(plan[i].req, plan[i].typed, plan[i].want);
        end

        for (int p = 0; p < RUN_PHASES; p++) begin
            case (p)
                0:
                begin
                    rpd   = 8'd1;
                    cyc   = 7'd1;
                    delay = 16'd0;
                end
                3:
                begin
                    rpd   = 8'd255;
                    cyc   = 7'd127;
                    delay = 16'hFFFF;
                end
                4:
                begin
                    rpd   = 8'd2;
                    cyc   = 7'd1;
                    delay = 16'd1;
                end
                default:
                begin
                    rpd = RPD_W'($urandom_range(0, 4));
                    cyc = CYC_W'($urandom_range(0, 3));
                    case ($urandom_range(0, 3))
                        0: delay = 16'd0;
                        1: delay = 16'hFFFF;
                        2: delay = SAMPLE_W'($urandom);
                        default: delay = SAMPLE_W'($urandom_range(1, 300));
                    endcase
                end
            endcase
            write_reg(CFG_READS_PER_DIR, {8'd0, rpd});
            write_reg(CFG_CYCLE_COUNT, {9'd0, cyc});
            write_reg(CFG_SETTLE_DELAY, delay);
            sender_gaps = (p != RUN_PHASES - 1) && ($urandom_range(0, 3) != 0);
            sink_stalls = (p != RUN_PHASES - 1) && ($urandom_range(0, 3) != 0);
            if ($urandom_range(0, 3) == 0)
                clock_ms = 32'hFFFF_FF00 + $urandom_range(0, 255);
            else
                clock_ms = $urandom;
            repeat (ITEMS_PER_PHASE) send_request(next_random_request(), 1'b0, '0);
        end

        req_bus.valid <= 1'b0;
        while (pending_status_q.size() != 0) @(posedge clk);
        repeat (10) @(posedge clk);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl/core
rtl/core/swcal_pkg.sv
rtl/core/swcal_in_if.sv
rtl/core/swcal_out_if.sv
rtl/core/swcal_cfg_if.sv
rtl/core/sweep_calibration_min_max_sequencer_top.sv
bench/sweep_calibration_min_max_sequencer_top_test.sv
